@@ src/occ_pkg.sv @@
// ----------------------------------------------------------------------------
// Cosine centroid clusterer package
// Shared types and constants: commands, results, divider handshake, engine
// state encoding and configuration register indexes.
// ----------------------------------------------------------------------------
package occ_pkg;

  localparam int unsigned FQ_DEPTH = 4;
  localparam int unsigned FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int unsigned DIV_W    = 32;
  localparam int unsigned SEG_W    = 32;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_CAP       = 1'b1;

  localparam logic [15:0] THR_RESET = 16'h4000;
  localparam logic [15:0] SIM_MIN   = 16'h8000;
  localparam logic [15:0] SIM_MAX   = 16'h7fff;

  typedef enum logic [1:0] {
    CMD_ELEM,
    CMD_FINAL,
    CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e        op;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  speaker_index;
    logic        new_speaker;
    logic [15:0] best_similarity;
  } res_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SC_RD,
    S_SC_MUL,
    S_SC_ACC,
    S_SC_END,
    S_DECIDE,
    S_EMIT,
    S_CP_RD,
    S_CP_WR,
    S_CNT_RD,
    S_CNT_WR,
    S_MN_RD,
    S_MN_SUB,
    S_MN_DIV,
    S_MN_WR,
    S_MN_SQ,
    S_SQ_CHK,
    S_SQRT,
    S_NM_RD,
    S_NM_SUB,
    S_NM_DIV,
    S_NM_WR
  } eng_state_e;

endpackage

@@ src/occ_front.sv @@
// ----------------------------------------------------------------------------
// Clusterer front end
// Accepts input items, turns each into an element, final-element or clear
// command and holds the commands in a short queue for the engine.
// ----------------------------------------------------------------------------
module occ_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic          kind_i,
  input  logic [15:0]   element_value_i,
  input  logic          last_element_i,
  output occ_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_pop_i
);

  occ_pkg::cmd_t                   fifo_q [occ_pkg::FQ_DEPTH];
  logic [occ_pkg::FQ_PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [occ_pkg::FQ_PTR_W:0]      fill_q;
  occ_pkg::cmd_t                   in_cmd;
  logic                            push_ok, pop_ok;

  always_comb begin
    in_cmd.value = element_value_i;
    if (kind_i) begin
      in_cmd.op = occ_pkg::CMD_CLEAR;
    end else if (last_element_i) begin
      in_cmd.op = occ_pkg::CMD_FINAL;
    end else begin
      in_cmd.op = occ_pkg::CMD_ELEM;
    end
  end

  assign full_o      = (fill_q == (occ_pkg::FQ_PTR_W+1)'(occ_pkg::FQ_DEPTH));
  assign cmd_valid_o = (fill_q != '0);
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      fifo_q[wr_ptr_q] <= in_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

@@ src/occ_div.sv @@
// ----------------------------------------------------------------------------
// Clusterer serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module occ_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  occ_pkg::div_req_t req_i,
  output occ_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W  = occ_pkg::DIV_W;
  localparam int unsigned CW = $clog2(W);

  logic [W-1:0]  rem_q, quo_q, den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem_q, quo_q[W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? W'(trial - {1'b0, den_q}) : trial[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(W-1));
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == CW'(W-1))) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ src/occ_sqrt.sv @@
// ----------------------------------------------------------------------------
// Clusterer integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module occ_sqrt #(
  parameter int unsigned SQ_W = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SQ_W-1:0]   radicand_i,
  output logic              done_o,
  output logic [SQ_W/2-1:0] root_o
);

  logic [SQ_W-1:0] x_q, r_q, bit_q;
  logic            busy_q, done_q;
  logic [SQ_W:0]   trial;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy_q) begin
      if ({1'b0, x_q} >= trial) begin
        x_q <= x_q - trial[SQ_W-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && bit_q[0];
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[SQ_W/2-1:0];

endmodule

@@ src/occ_engine.sv @@
// ----------------------------------------------------------------------------
// Clusterer engine
// Buffers the embedding, scores it against the stored centroids, decides
// between joining and creating a speaker, and updates the centroid store.
// ----------------------------------------------------------------------------
module occ_engine #(
  parameter int unsigned EMBED_DIM    = 256,
  parameter int unsigned MAX_CLUSTERS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  occ_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  logic [15:0]   thr_i,
  input  logic [4:0]    cap_i,
  output occ_pkg::res_t res_o,
  output logic          empty_o,
  input  logic          pop_i
);

  localparam int unsigned EI_W      = $clog2(EMBED_DIM);
  localparam int unsigned LEN_W     = $clog2(EMBED_DIM + 1);
  localparam int unsigned CI_W      = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned CEN_DEPTH = MAX_CLUSTERS * EMBED_DIM;
  localparam int unsigned AW        = $clog2(CEN_DEPTH);
  localparam int unsigned ACC_W     = 32 + $clog2(EMBED_DIM);
  localparam int unsigned SC_W      = ACC_W - 15;
  localparam int unsigned SQ_W      = 2 * ((32 + $clog2(EMBED_DIM)) / 2);
  localparam int unsigned NRM_W     = SQ_W / 2;
  localparam int unsigned DW        = occ_pkg::DIV_W;

  // Memories and their read registers.
  logic [15:0]              buf_mem [EMBED_DIM];
  logic [15:0]              cen_mem [CEN_DEPTH];
  logic [occ_pkg::SEG_W-1:0] seg_mem [MAX_CLUSTERS];
  logic signed [15:0]       buf_rd_q, cen_rd_q;
  logic [occ_pkg::SEG_W-1:0] seg_rd_q;

  occ_pkg::eng_state_e state_q, state_d;
  logic [LEN_W-1:0]    pos_q, len_q;
  logic [CNT_W-1:0]    count_q;
  logic [EI_W-1:0]     elem_q;
  logic [CI_W-1:0]     clus_q, bidx_q, target_q;
  logic [AW-1:0]       base_q;
  logic signed [ACC_W-1:0] acc_q;
  logic signed [31:0]  prod_q;
  logic signed [15:0]  best_q, v_q;
  logic                bvalid_q, is_new_q, neg_q, out_valid_q;
  logic [occ_pkg::SEG_W-1:0] n_q;
  logic [SQ_W-1:0]     sq_q;
  logic [NRM_W-1:0]    norm_q;
  occ_pkg::res_t       res_q;

  // Control strobes.
  logic                buf_we, cen_we, seg_we, sqrt_start, sqrt_done;
  logic [15:0]         cen_wdata;
  logic [occ_pkg::SEG_W-1:0] seg_wdata;
  logic [NRM_W-1:0]    sqrt_root;
  occ_pkg::div_req_t   div_req;
  occ_pkg::div_rsp_t   div_rsp;

  // Datapath helpers.
  logic signed [15:0]  e_val, score, newv, nm_val;
  logic                elem_last, sc_last, pos_in;
  logic [AW-1:0]       cen_addr;
  logic [SC_W-1:0]     sc_w;
  logic [SC_W-16:0]    sc_top;
  logic signed [16:0]  diff, newv17;
  logic [16:0]         mn_mag, nm_mag;
  logic [CNT_W-1:0]    cap_eff;
  logic [CI_W-1:0]     tgt_d;
  logic                new_d;
  logic [CI_W+3:0]     tgt_ext;
  logic [occ_pkg::SEG_W-1:0] n_next;

  assign e_val     = (LEN_W'(elem_q) < len_q) ? buf_rd_q : '0;
  assign elem_last = (elem_q == EI_W'(EMBED_DIM - 1));
  assign cen_addr  = base_q + AW'(elem_q);
  assign sc_last   = ((CNT_W'(clus_q) + CNT_W'(1)) == count_q);
  assign pos_in    = (pos_q < LEN_W'(EMBED_DIM));

  // Score: floor shift by 15, clamped to Q1.15.
  assign sc_w   = acc_q[ACC_W-1:15];
  assign sc_top = sc_w[SC_W-1:15];
  always_comb begin
    if ((&sc_top) || !(|sc_top)) begin
      score = sc_w[15:0];
    end else if (sc_top[SC_W-16]) begin
      score = occ_pkg::SIM_MIN;
    end else begin
      score = occ_pkg::SIM_MAX;
    end
  end

  // Running mean and renormalization arithmetic.
  assign diff   = {e_val[15], e_val} - {cen_rd_q[15], cen_rd_q};
  assign mn_mag = diff[16] ? 17'(~diff + 17'sd1) : diff;
  assign nm_mag = cen_rd_q[15] ? 17'(~{cen_rd_q[15], cen_rd_q} + 17'd1)
                               : {1'b0, cen_rd_q};
  assign newv17 = neg_q ? ({v_q[15], v_q} - {1'b0, div_rsp.quotient[15:0]})
                        : ({v_q[15], v_q} + {1'b0, div_rsp.quotient[15:0]});
  assign newv   = newv17[15:0];

  always_comb begin
    if (|div_rsp.quotient[DW-1:15]) begin
      nm_val = neg_q ? occ_pkg::SIM_MIN : occ_pkg::SIM_MAX;
    end else if (neg_q) begin
      nm_val = 16'(~div_rsp.quotient[15:0] + 16'd1);
    end else begin
      nm_val = div_rsp.quotient[15:0];
    end
  end

  assign n_next = (&seg_rd_q) ? seg_rd_q : seg_rd_q + 1'b1;

  // Speaker decision.
  always_comb begin
    if ((cap_i == '0) || (32'(cap_i) > MAX_CLUSTERS)) begin
      cap_eff = CNT_W'(MAX_CLUSTERS);
    end else begin
      cap_eff = CNT_W'(cap_i);
    end
    if (bvalid_q && (best_q >= $signed(thr_i))) begin
      tgt_d = bidx_q;
      new_d = 1'b0;
    end else if (count_q >= cap_eff) begin
      tgt_d = bvalid_q ? bidx_q : '0;
      new_d = 1'b0;
    end else begin
      tgt_d = count_q[CI_W-1:0];
      new_d = 1'b1;
    end
  end

  assign tgt_ext = {4'b0000, target_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      occ_pkg::S_IDLE: begin
        if (cmd_valid_i && (cmd_i.op == occ_pkg::CMD_FINAL)) begin
          state_d = (count_q == '0) ? occ_pkg::S_DECIDE : occ_pkg::S_SC_RD;
        end
      end
      occ_pkg::S_SC_RD:  state_d = occ_pkg::S_SC_MUL;
      occ_pkg::S_SC_MUL: state_d = occ_pkg::S_SC_ACC;
      occ_pkg::S_SC_ACC: state_d = elem_last ? occ_pkg::S_SC_END : occ_pkg::S_SC_RD;
      occ_pkg::S_SC_END: state_d = sc_last ? occ_pkg::S_DECIDE : occ_pkg::S_SC_RD;
      occ_pkg::S_DECIDE: state_d = occ_pkg::S_EMIT;
      occ_pkg::S_EMIT: begin
        if (!out_valid_q) begin
          state_d = is_new_q ? occ_pkg::S_CP_RD : occ_pkg::S_CNT_RD;
        end
      end
      occ_pkg::S_CP_RD:  state_d = occ_pkg::S_CP_WR;
      occ_pkg::S_CP_WR:  state_d = elem_last ? occ_pkg::S_IDLE : occ_pkg::S_CP_RD;
      occ_pkg::S_CNT_RD: state_d = occ_pkg::S_CNT_WR;
      occ_pkg::S_CNT_WR: state_d = occ_pkg::S_MN_RD;
      occ_pkg::S_MN_RD:  state_d = occ_pkg::S_MN_SUB;
      occ_pkg::S_MN_SUB: state_d = occ_pkg::S_MN_DIV;
      occ_pkg::S_MN_DIV: state_d = div_rsp.done ? occ_pkg::S_MN_WR : occ_pkg::S_MN_DIV;
      occ_pkg::S_MN_WR:  state_d = occ_pkg::S_MN_SQ;
      occ_pkg::S_MN_SQ:  state_d = elem_last ? occ_pkg::S_SQ_CHK : occ_pkg::S_MN_RD;
      occ_pkg::S_SQ_CHK: state_d = (sq_q == '0) ? occ_pkg::S_IDLE : occ_pkg::S_SQRT;
      occ_pkg::S_SQRT:   state_d = sqrt_done ? occ_pkg::S_NM_RD : occ_pkg::S_SQRT;
      occ_pkg::S_NM_RD:  state_d = occ_pkg::S_NM_SUB;
      occ_pkg::S_NM_SUB: state_d = occ_pkg::S_NM_DIV;
      occ_pkg::S_NM_DIV: state_d = div_rsp.done ? occ_pkg::S_NM_WR : occ_pkg::S_NM_DIV;
      occ_pkg::S_NM_WR:  state_d = elem_last ? occ_pkg::S_IDLE : occ_pkg::S_NM_RD;
      default:           state_d = occ_pkg::S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd_pop_o        = 1'b0;
    buf_we           = 1'b0;
    cen_we           = 1'b0;
    cen_wdata        = e_val;
    seg_we           = 1'b0;
    seg_wdata        = n_next;
    sqrt_start       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DW'(mn_mag) + (n_q >> 1);
    div_req.divisor  = n_q;
    case (state_q)
      occ_pkg::S_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        buf_we    = cmd_valid_i && pos_in && ((cmd_i.op == occ_pkg::CMD_ELEM) ||
                                              (cmd_i.op == occ_pkg::CMD_FINAL));
      end
      occ_pkg::S_CP_WR: begin
        cen_we    = 1'b1;
        seg_we    = elem_last;
        seg_wdata = occ_pkg::SEG_W'(1);
      end
      occ_pkg::S_CNT_WR: seg_we = 1'b1;
      occ_pkg::S_MN_SUB: div_req.start = 1'b1;
      occ_pkg::S_MN_WR: begin
        cen_we    = 1'b1;
        cen_wdata = newv;
      end
      occ_pkg::S_SQ_CHK: sqrt_start = (sq_q != '0);
      occ_pkg::S_NM_SUB: begin
        div_req.start    = 1'b1;
        div_req.dividend = {nm_mag, 15'b0} + DW'(norm_q >> 1);
        div_req.divisor  = DW'(norm_q);
      end
      occ_pkg::S_NM_WR: begin
        cen_we    = 1'b1;
        cen_wdata = nm_val;
      end
      default: ;
    endcase
  end

  // Memories.
  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      buf_mem[pos_q[EI_W-1:0]] <= cmd_i.value;
    end
    buf_rd_q <= buf_mem[elem_q];
  end

  always_ff @(posedge clk_i) begin
    if (cen_we) begin
      cen_mem[cen_addr] <= cen_wdata;
    end
    cen_rd_q <= cen_mem[cen_addr];
  end

  always_ff @(posedge clk_i) begin
    if (seg_we) begin
      seg_mem[target_q] <= seg_wdata;
    end
    seg_rd_q <= seg_mem[target_q];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= occ_pkg::S_IDLE;
      pos_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == occ_pkg::S_IDLE && cmd_valid_i) begin
        case (cmd_i.op)
          occ_pkg::CMD_CLEAR: begin
            count_q <= '0;
            pos_q   <= '0;
          end
          occ_pkg::CMD_ELEM: begin
            if (pos_in) begin
              pos_q <= pos_q + 1'b1;
            end
          end
          occ_pkg::CMD_FINAL: pos_q <= '0;
          default: ;
        endcase
      end
      if (state_q == occ_pkg::S_CP_WR && elem_last) begin
        count_q <= count_q + 1'b1;
      end
      if (state_q == occ_pkg::S_EMIT && !out_valid_q) begin
        out_valid_q <= 1'b1;
      end else if (pop_i && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      occ_pkg::S_IDLE: begin
        len_q    <= pos_in ? pos_q + 1'b1 : pos_q;
        elem_q   <= '0;
        clus_q   <= '0;
        base_q   <= '0;
        acc_q    <= '0;
        best_q   <= occ_pkg::SIM_MIN;
        bvalid_q <= 1'b0;
      end
      occ_pkg::S_SC_MUL: prod_q <= e_val * cen_rd_q;
      occ_pkg::S_SC_ACC: begin
        acc_q <= acc_q + ACC_W'(prod_q);
        if (!elem_last) begin
          elem_q <= elem_q + 1'b1;
        end
      end
      occ_pkg::S_SC_END: begin
        if (score > best_q) begin
          best_q   <= score;
          bidx_q   <= clus_q;
          bvalid_q <= 1'b1;
        end
        acc_q  <= '0;
        elem_q <= '0;
        clus_q <= clus_q + 1'b1;
        base_q <= base_q + AW'(EMBED_DIM);
      end
      occ_pkg::S_DECIDE: begin
        target_q <= tgt_d;
        is_new_q <= new_d;
        base_q   <= AW'(int'(tgt_d) * EMBED_DIM);
        elem_q   <= '0;
      end
      occ_pkg::S_EMIT: begin
        if (!out_valid_q) begin
          res_q.speaker_index   <= tgt_ext[3:0];
          res_q.new_speaker     <= is_new_q;
          res_q.best_similarity <= best_q;
        end
      end
      occ_pkg::S_CP_WR: begin
        if (!elem_last) begin
          elem_q <= elem_q + 1'b1;
        end
      end
      occ_pkg::S_CNT_WR: begin
        n_q    <= n_next;
        elem_q <= '0;
        sq_q   <= '0;
      end
      occ_pkg::S_MN_SUB: begin
        v_q   <= cen_rd_q;
        neg_q <= diff[16];
      end
      occ_pkg::S_MN_WR: prod_q <= newv * newv;
      occ_pkg::S_MN_SQ: begin
        sq_q <= sq_q + SQ_W'(unsigned'(prod_q));
        if (!elem_last) begin
          elem_q <= elem_q + 1'b1;
        end
      end
      occ_pkg::S_SQRT: begin
        norm_q <= sqrt_root;
        elem_q <= '0;
      end
      occ_pkg::S_NM_SUB: neg_q <= cen_rd_q[15];
      occ_pkg::S_NM_WR: begin
        if (!elem_last) begin
          elem_q <= elem_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  occ_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  occ_sqrt #(
    .SQ_W (SQ_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sq_q),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  assign res_o   = res_q;
  assign empty_o = !out_valid_q;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_CLUSTERS))
    else $error("speaker count exceeds store size");

  a_new_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == occ_pkg::S_EMIT && !out_valid_q && is_new_q) |-> (count_q < cap_eff))
    else $error("new speaker created at or above the cap");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_pop_o && cmd_i.op == occ_pkg::CMD_CLEAR) |=> (count_q == '0))
    else $error("clear did not empty the store");
`endif

endmodule

@@ src/online_cosine_centroid_clusterer.sv @@
// ----------------------------------------------------------------------------
// Online cosine centroid clusterer
// Leader clustering of unit embeddings with running-mean centroids.
// ----------------------------------------------------------------------------
// Input items are pushed one Q1.15 element per transaction (push while full is
// low); the flagged last element closes an embedding, and a clear item empties
// the speaker store. Results are read as from a queue: while empty is low the
// ports hold the oldest result, and pop takes it. One result per embedding.
// Configuration writes use cfg_valid_i/cfg_ready_o and are taken every cycle;
// the user must make them only while the block is idle; the block itself does
// not enforce this. The idle engine buffers the elements. On the last element,
// each stored speaker is scored by a memory read, a multiply and an accumulate
// per element; the speaker is then decided and the result emitted. A new
// speaker has the embedding copied into its centroid. Joining updates the
// running mean element by element, takes the square root of the sum of squares
// and renormalizes element by element; the shared serial divider serves both
// passes. A four-entry command queue takes items while the engine works and
// raises full once it holds four, until the engine returns to idle. A result
// that is not popped holds the engine before its next result, and input then
// stalls once the queue fills. Reset empties the queues and the speaker count;
// centroid entries are only read after being written.
// ----------------------------------------------------------------------------
module online_cosine_centroid_clusterer #(
  parameter int unsigned EMBED_DIM    = 256,
  parameter int unsigned MAX_CLUSTERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [15:0] element_value_i,
  input  logic        last_element_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  speaker_index_o,
  output logic        new_speaker_o,
  output logic [15:0] best_similarity_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0]   thr_q;
  logic [4:0]    cap_q;
  occ_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_pop;
  occ_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= occ_pkg::THR_RESET;
      cap_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        occ_pkg::REG_THRESHOLD: thr_q <= cfg_data_i;
        occ_pkg::REG_CAP:       cap_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  occ_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .kind_i          (kind_i),
    .element_value_i (element_value_i),
    .last_element_i  (last_element_i),
    .cmd_o           (cmd),
    .cmd_valid_o     (cmd_valid),
    .cmd_pop_i       (cmd_pop)
  );

  occ_engine #(
    .EMBED_DIM    (EMBED_DIM),
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .thr_i       (thr_q),
    .cap_i       (cap_q),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign speaker_index_o   = res.speaker_index;
  assign new_speaker_o     = res.new_speaker;
  assign best_similarity_o = res.best_similarity;

endmodule
